[hdl/swm_pkg.sv]
// ============================================================================
// swm_pkg
// Shared types and constants for the sliding-window median filter.
// ============================================================================
package swm_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 8;

    // Value loaded into every window entry on reset or length change
    localparam logic signed [DATA_W-1:0] FILL_VALUE = 32'sd150;

    // Link passed from a cell to its upper neighbor:
    // lt_eff  - cell is active and its value is below the incoming sample
    // rem_le  - the entry being retired sits at this cell or below it
    typedef struct packed {
        logic lt_eff;
        logic rem_le;
    } swm_link_t;

endpackage

[hdl/swm_cell.sv]
// ============================================================================
// swm_cell
// One slot of the sorted window: holds a sample and its window slot tag.
// ============================================================================
module swm_cell
    import swm_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int IW         = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     refill,
    input  logic                     step,
    input  logic                     active,
    input  logic signed [DATA_W-1:0] sample,
    input  logic [IW-1:0]            wp,
    input  logic signed [DATA_W-1:0] prev_val,
    input  logic [IW-1:0]            prev_idx,
    input  swm_link_t                prev_link,
    input  logic signed [DATA_W-1:0] next_val,
    input  logic [IW-1:0]            next_idx,
    input  logic                     next_lt,
    output logic signed [DATA_W-1:0] val,
    output logic [IW-1:0]            idx,
    output swm_link_t                link
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            idx_next;
    logic                     own_lt;
    logic                     lt_here;
    logic                     lt_below;

    assign own_lt      = active && (val_reg < sample);
    assign link.lt_eff = own_lt;
    assign link.rem_le = prev_link.rem_le | (active && (idx_reg == wp));

    // Ordering of the compacted window at this slot and the one below
    assign lt_here  = link.rem_le ? next_lt : own_lt;
    assign lt_below = prev_link.rem_le ? own_lt : prev_link.lt_eff;

    always_comb
    begin
        val_next = val_reg;
        idx_next = idx_reg;
        if (refill)
        begin
            val_next = FILL_VALUE;
            idx_next = IW'(CELL_INDEX);
        end
        else if (step && active)
        begin
            if (lt_here)
            begin
                // keep the compacted entry at this slot
                val_next = link.rem_le ? next_val : val_reg;
                idx_next = link.rem_le ? next_idx : idx_reg;
            end
            else if (lt_below)
            begin
                // take the new sample here
                val_next = sample;
                idx_next = wp;
            end
            else
            begin
                // shift the compacted entry from below up by one
                val_next = prev_link.rem_le ? val_reg : prev_val;
                idx_next = prev_link.rem_le ? idx_reg : prev_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= FILL_VALUE;
            idx_reg <= IW'(CELL_INDEX);
        end
        else
        begin
            val_reg <= val_next;
            idx_reg <= idx_next;
        end
    end

    assign val = val_reg;
    assign idx = idx_reg;

endmodule

[hdl/sliding_window_median_int_core.sv]
// ============================================================================
// sliding_window_median_int_core
// Running median over an odd-length sliding window of signed samples.
// ============================================================================
// Usage:
//   sample channel  : one signed 32-bit sample per transaction.
//   median channel  : one signed 32-bit median per accepted sample, in order.
//   cfg channel     : writes requested_length; the window length becomes the
//                     request clamped to MAX_WINDOW, raised to odd if even.
//                     A write refills the window with 150 and rewinds the
//                     write position. Write only while the block is idle;
//                     sample_ready is held low during a write.
// The window is a chain of MAX_WINDOW cells kept in sorted order. Each
// accepted sample retires the entry at the write position and lands in its
// sorted slot in the same cycle, every cell looking only at its neighbors.
// A sample updates the cells and sets pending; then the result register loads.
// Throughput: one sample per cycle while the receiver keeps up; the single
// result register, loaded from the middle cell, sets that figure.
// Reset: window filled with 150, write position 0, length from request 5.
// Stall: while a median waits and another is pending, sample_ready drops;
// nothing is lost or repeated.
// ============================================================================
module sliding_window_median_int_core
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 15
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     median_valid,
    input  logic                     median_ready,
    output logic signed [DATA_W-1:0] median,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [REQ_W-1:0]         requested_length
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam logic [REQ_W-1:0] RESET_REQ = 8'd5;

    // Map a request onto the effective (odd unless clamped) window length
    function automatic logic [LW-1:0] len_of(input logic [REQ_W-1:0] req);
        logic [REQ_W:0] up;
        logic [LW-1:0]  res;
        up = {1'b0, req} + 9'd1;
        if ({1'b0, req} > (REQ_W+1)'(MAX_WINDOW))
            res = LW'(MAX_WINDOW);
        else if (!req[0])
            res = (up > (REQ_W+1)'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : LW'(up);
        else
            res = LW'(req);
        return res;
    endfunction

    logic [LW-1:0]            len_reg;
    logic [LW-1:0]            len_next;
    logic [IW-1:0]            mid_reg;
    logic [IW-1:0]            mid_next;
    logic [IW-1:0]            wp_reg;
    logic [IW-1:0]            wp_next;
    logic                     pending_reg;
    logic                     pending_next;
    logic                     median_valid_reg;
    logic                     median_valid_next;
    logic signed [DATA_W-1:0] median_reg;
    logic signed [DATA_W-1:0] median_next;

    logic                     cfg_fire;
    logic                     step;
    logic                     out_free;
    logic                     load_out;
    logic [LW-1:0]            wp_inc;

    logic signed [DATA_W-1:0] cell_val [MAX_WINDOW];
    logic [IW-1:0]            cell_idx [MAX_WINDOW];
    swm_link_t                cell_link [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]    retire_hit;

    // Config writes are taken at once; the block is idle by contract
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Result register frees up when empty or being drained this cycle;
    // hold off samples while a length write lands
    assign out_free     = !median_valid_reg || median_ready;
    assign load_out     = pending_reg && out_free;
    assign sample_ready = (!pending_reg || out_free) && !cfg_fire;
    assign step         = sample_valid && sample_ready && !cfg_fire;

    // Build the sorted cell chain
    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        logic signed [DATA_W-1:0] pv;
        logic [IW-1:0]            pi;
        swm_link_t                pl;
        logic signed [DATA_W-1:0] nv;
        logic [IW-1:0]            ni;
        logic                     nl;
        logic                     act;

        assign act = (LW'(k) < len_reg);

        if (k == 0)
        begin : g_lo
            // bottom edge: everything below is "less than" and nothing retired
            assign pv = '0;
            assign pi = '0;
            assign pl = '{lt_eff: 1'b1, rem_le: 1'b0};
        end
        else
        begin : g_mid_lo
            assign pv = cell_val[k-1];
            assign pi = cell_idx[k-1];
            assign pl = cell_link[k-1];
        end

        if (k == MAX_WINDOW - 1)
        begin : g_hi
            assign nv = '0;
            assign ni = '0;
            assign nl = 1'b0;
        end
        else
        begin : g_mid_hi
            assign nv = cell_val[k+1];
            assign ni = cell_idx[k+1];
            assign nl = cell_link[k+1].lt_eff;
        end

        assign retire_hit[k] = act && (cell_idx[k] == wp_reg);

        swm_cell #(
            .CELL_INDEX (k),
            .IW         (IW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .refill    (cfg_fire),
            .step      (step),
            .active    (act),
            .sample    (sample),
            .wp        (wp_reg),
            .prev_val  (pv),
            .prev_idx  (pi),
            .prev_link (pl),
            .next_val  (nv),
            .next_idx  (ni),
            .next_lt   (nl),
            .val       (cell_val[k]),
            .idx       (cell_idx[k]),
            .link      (cell_link[k])
        );
    end

    // Advance the write position, wrapping at the window length
    assign wp_inc = LW'(wp_reg) + LW'(1);

    always_comb
    begin
        len_next          = len_reg;
        mid_next          = mid_reg;
        wp_next           = wp_reg;
        pending_next      = pending_reg;
        median_valid_next = median_valid_reg;
        median_next       = median_reg;

        // drop the result once taken; reload from the middle cell
        if (median_valid_reg && median_ready)
            median_valid_next = 1'b0;
        if (load_out)
        begin
            median_next       = cell_val[mid_reg];
            median_valid_next = 1'b1;
            pending_next      = 1'b0;
        end

        if (cfg_fire)
        begin
            len_next = len_of(requested_length);
            mid_next = IW'(len_of(requested_length) >> 1);
            wp_next  = '0;
        end
        else if (step)
        begin
            wp_next      = (wp_inc >= len_reg) ? '0 : IW'(wp_inc);
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= len_of(RESET_REQ);
            mid_reg          <= IW'(len_of(RESET_REQ) >> 1);
            wp_reg           <= '0;
            pending_reg      <= 1'b0;
            median_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            mid_reg          <= mid_next;
            wp_reg           <= wp_next;
            pending_reg      <= pending_next;
            median_valid_reg <= median_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign median_valid = median_valid_reg;
    assign median       = median_reg;

    // Exactly one active cell holds the entry being retired
    a_one_retire: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> $onehot(retire_hit))
        else $error("retire position not unique in cell chain");

    // Write position stays inside the window
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(wp_reg) < len_reg)
        else $error("write position outside window");

    // An accepted sample always leaves a result pending
    a_step_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> pending_reg)
        else $error("accepted sample left no pending result");

    // A pending result is loaded as soon as the output register frees up
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg && out_free && !step) |=> (median_valid_reg && !pending_reg))
        else $error("pending result not moved to output");

endmodule
